// File: hdl/pltw_pkg.sv
// shared types and constants of the four-level page table walker
`default_nettype none

package pltw_pkg;

    localparam int VA_W        = 48;
    localparam int SIDX_W      = 15;
    localparam int WORD_W      = 64;
    localparam int STATUS_W    = 2;
    localparam int IDX_W       = 9;
    localparam int PAGE_SHIFT  = 12;
    localparam int ROOT_W      = 6;
    localparam int IN_DATA_W   = 128;
    localparam int OUT_DATA_W  = 152;

    typedef enum logic [1:0] {
        CMD_TRANSLATE = 2'd0,
        CMD_UNMAP     = 2'd1,
        CMD_WRITE     = 2'd2,
        CMD_READ      = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NOT_PRESENT = 2'd1,
        STATUS_RANGE       = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        LEVEL_PML4 = 2'd0,
        LEVEL_PDPT = 2'd1,
        LEVEL_PD   = 2'd2,
        LEVEL_PT   = 2'd3
    } t_level;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_READ,
        ST_UNMAP_WR,
        ST_DONE
    } t_state;

    // first member lands in the highest bits, so status ends up at bit 0
    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              released;
        logic [SIDX_W-1:0] leaf_location;
        logic [WORD_W-1:0] phys_frame;
        t_status           status;
    } t_result;

    // 9-bit table index of a virtual address for one walk level
    function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                  input t_level lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            LEVEL_PML4: idx = va[39 +: IDX_W];
            LEVEL_PDPT: idx = va[30 +: IDX_W];
            LEVEL_PD:   idx = va[21 +: IDX_W];
            LEVEL_PT:   idx = va[12 +: IDX_W];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: hdl/four_level_page_table_walker_core.sv
// four-level page table walker: one command in, one result beat out
// a translate or unmap walks with up to four dependent reads of the synchronous table store,
// and an unmap then clears the leaf entry; a write or a read makes one store access
// one command at a time, the next taken only after the last has gone to the output register;
// a new command is taken while the last result still waits in the output register
// reset is synchronous; no command is taken during the store sweep after reset; root_frame 0
`default_nettype none

module four_level_page_table_walker_core #(
    parameter int TABLE_FRAMES = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [pltw_pkg::ROOT_W-1:0]         i_cfg_wdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // virt_addr[47:0], store_index[62:48], store_data[126:63], zero[127]
    input  wire logic [pltw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // cmd[1:0]
    input  wire logic [1:0]                          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // status[1:0], phys_frame[65:2], leaf_location[80:66], released[81],
    // read_data[145:82], zero[151:146]
    output logic      [pltw_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int FRAME_W     = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int ADDR_W      = FRAME_W + pltw_pkg::IDX_W;
    localparam int STORE_WORDS = TABLE_FRAMES * (1 << pltw_pkg::IDX_W);
    localparam int PTR_W       = pltw_pkg::WORD_W - pltw_pkg::PAGE_SHIFT;

    pltw_pkg::t_state  r_state, n_state;
    logic [pltw_pkg::ROOT_W-1:0] r_root_frame;
    pltw_pkg::t_cmd    r_cmd, n_cmd;
    logic [pltw_pkg::VA_W-1:0] r_va, n_va;
    pltw_pkg::t_level  r_level, n_level;
    logic [ADDR_W-1:0] r_cur_addr, n_cur_addr;
    pltw_pkg::t_result r_res, n_res;
    pltw_pkg::t_result r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic                         w_mem_rd_en;
    logic [ADDR_W-1:0]            w_mem_rd_addr;
    logic                         w_mem_wr_en;
    logic [ADDR_W-1:0]            w_mem_wr_addr;
    logic [pltw_pkg::WORD_W-1:0]  w_mem_wr_data;
    logic [pltw_pkg::WORD_W-1:0]  w_rd_data;
    logic                         w_clearing;

    pltw_pkg::t_cmd               w_in_cmd;
    logic [pltw_pkg::VA_W-1:0]    w_in_va;
    logic [pltw_pkg::SIDX_W-1:0]  w_in_sidx;
    logic [pltw_pkg::WORD_W-1:0]  w_in_sdata;
    logic                         w_in_fire;
    logic                         w_sidx_ok;
    logic [ADDR_W-1:0]            w_sidx_addr;
    logic                         w_root_ok;
    logic [ADDR_W-1:0]            w_root_addr;
    logic                         w_absent;
    logic                         w_at_leaf;
    logic                         w_ptr_ok;
    logic [ADDR_W-1:0]            w_next_addr;
    logic                         w_out_free;

    assign w_in_cmd   = pltw_pkg::t_cmd'(s_axis_tuser);
    assign w_in_va    = s_axis_tdata[47:0];
    assign w_in_sidx  = s_axis_tdata[62:48];
    assign w_in_sdata = s_axis_tdata[126:63];
    assign w_in_fire  = s_axis_tvalid && s_axis_tready;

    assign w_sidx_ok   = 32'(w_in_sidx) < 32'(STORE_WORDS);
    assign w_sidx_addr = ADDR_W'(w_in_sidx);
    assign w_root_ok   = 32'(r_root_frame) < 32'(TABLE_FRAMES);
    assign w_root_addr = {FRAME_W'(r_root_frame),
                          pltw_pkg::va_index(w_in_va, pltw_pkg::LEVEL_PML4)};

    // walk decisions on the entry just read
    assign w_absent    = !w_rd_data[0];
    assign w_at_leaf   = (r_level == pltw_pkg::LEVEL_PT);
    assign w_ptr_ok    = w_rd_data[pltw_pkg::WORD_W-1:pltw_pkg::PAGE_SHIFT] < PTR_W'(TABLE_FRAMES);
    assign w_next_addr = {w_rd_data[pltw_pkg::PAGE_SHIFT +: FRAME_W],
                          pltw_pkg::va_index(r_va, pltw_pkg::t_level'(r_level + 2'd1))};
    assign w_out_free  = !r_out_valid || m_axis_tready;

    pltw_store #(
        .TABLE_FRAMES(TABLE_FRAMES)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_mem_rd_en),
        .i_rd_addr  (w_mem_rd_addr),
        .i_wr_en    (w_mem_wr_en),
        .i_wr_addr  (w_mem_wr_addr),
        .i_wr_data  (w_mem_wr_data),
        .o_rd_data  (w_rd_data),
        .o_clearing (w_clearing)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pltw_pkg::ST_CLEAR: begin
                if (!w_clearing) begin
                    n_state = pltw_pkg::ST_IDLE;
                end
            end
            pltw_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    unique case (w_in_cmd)
                        pltw_pkg::CMD_WRITE:
                            n_state = pltw_pkg::ST_DONE;
                        pltw_pkg::CMD_READ:
                            n_state = w_sidx_ok ? pltw_pkg::ST_READ : pltw_pkg::ST_DONE;
                        pltw_pkg::CMD_TRANSLATE, pltw_pkg::CMD_UNMAP:
                            n_state = w_root_ok ? pltw_pkg::ST_WALK : pltw_pkg::ST_DONE;
                    endcase
                end
            end
            pltw_pkg::ST_WALK: begin
                priority if (w_absent) begin
                    n_state = pltw_pkg::ST_DONE;
                end else if (w_at_leaf) begin
                    n_state = (r_cmd == pltw_pkg::CMD_UNMAP) ? pltw_pkg::ST_UNMAP_WR
                                                             : pltw_pkg::ST_DONE;
                end else if (!w_ptr_ok) begin
                    n_state = pltw_pkg::ST_DONE;
                end else begin
                    n_state = pltw_pkg::ST_WALK;
                end
            end
            pltw_pkg::ST_READ:     n_state = pltw_pkg::ST_DONE;
            pltw_pkg::ST_UNMAP_WR: n_state = pltw_pkg::ST_DONE;
            pltw_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = pltw_pkg::ST_IDLE;
                end
            end
            default: n_state = pltw_pkg::ST_IDLE;
        endcase
    end

    // store accesses and datapath
    always_comb begin
        w_mem_rd_en   = 1'b0;
        w_mem_rd_addr = r_cur_addr;
        w_mem_wr_en   = 1'b0;
        w_mem_wr_addr = r_cur_addr;
        w_mem_wr_data = '0;
        n_cmd         = r_cmd;
        n_va          = r_va;
        n_level       = r_level;
        n_cur_addr    = r_cur_addr;
        n_res         = r_res;
        n_out         = r_out;
        n_out_valid   = r_out_valid && !m_axis_tready;
        unique case (r_state)
            pltw_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    n_cmd   = w_in_cmd;
                    n_va    = w_in_va;
                    n_level = pltw_pkg::LEVEL_PML4;
                    n_res   = '0;
                    unique case (w_in_cmd)
                        pltw_pkg::CMD_WRITE: begin
                            if (w_sidx_ok) begin
                                w_mem_wr_en   = 1'b1;
                                w_mem_wr_addr = w_sidx_addr;
                                w_mem_wr_data = w_in_sdata;
                            end else begin
                                n_res.status = pltw_pkg::STATUS_RANGE;
                            end
                        end
                        pltw_pkg::CMD_READ: begin
                            if (w_sidx_ok) begin
                                w_mem_rd_en   = 1'b1;
                                w_mem_rd_addr = w_sidx_addr;
                            end else begin
                                n_res.status = pltw_pkg::STATUS_RANGE;
                            end
                        end
                        pltw_pkg::CMD_TRANSLATE, pltw_pkg::CMD_UNMAP: begin
                            if (w_root_ok) begin
                                w_mem_rd_en   = 1'b1;
                                w_mem_rd_addr = w_root_addr;
                                n_cur_addr    = w_root_addr;
                            end else begin
                                n_res.status = pltw_pkg::STATUS_RANGE;
                            end
                        end
                    endcase
                end
            end
            pltw_pkg::ST_WALK: begin
                priority if (w_absent) begin
                    n_res.status = pltw_pkg::STATUS_NOT_PRESENT;
                end else if (w_at_leaf) begin
                    n_res.phys_frame    = {w_rd_data[pltw_pkg::WORD_W-1:pltw_pkg::PAGE_SHIFT],
                                           pltw_pkg::PAGE_SHIFT'(0)};
                    n_res.leaf_location = pltw_pkg::SIDX_W'(r_cur_addr);
                    n_res.released      = (r_cmd == pltw_pkg::CMD_UNMAP);
                end else if (!w_ptr_ok) begin
                    n_res.status = pltw_pkg::STATUS_RANGE;
                end else begin
                    w_mem_rd_en   = 1'b1;
                    w_mem_rd_addr = w_next_addr;
                    n_cur_addr    = w_next_addr;
                    n_level       = pltw_pkg::t_level'(r_level + 2'd1);
                end
            end
            pltw_pkg::ST_READ: begin
                n_res.read_data = w_rd_data;
            end
            pltw_pkg::ST_UNMAP_WR: begin
                // leaf address is still held from the last walk read
                w_mem_wr_en = 1'b1;
            end
            pltw_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pltw_pkg::ST_CLEAR;
            r_root_frame <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_root_frame <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_va       <= n_va;
        r_level    <= n_level;
        r_cur_addr <= n_cur_addr;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign s_axis_tready = (r_state == pltw_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(pltw_pkg::OUT_DATA_W - $bits(pltw_pkg::t_result))'(0), r_out};

    // no command may enter while the store is still being swept
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !s_axis_tready)
        else $error("command accepted during store clear");

    // the core never drives a store read and a store write together
    a_single_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_wr_en |-> !w_mem_rd_en)
        else $error("store read and write in one cycle");

    // a released frame only comes with a successful walk
    a_release_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.released) |-> (r_out.status == pltw_pkg::STATUS_OK))
        else $error("release reported on a failed walk");

    // failed commands carry no leaf information
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != pltw_pkg::STATUS_OK)
            |-> (r_out.phys_frame == '0 && r_out.leaf_location == '0))
        else $error("leaf fields set on a failed command");

    // the leaf write of an unmap lands on the entry the walk ended on
    a_unmap_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pltw_pkg::ST_UNMAP_WR) |-> ($past(r_state) == pltw_pkg::ST_WALK
            && w_mem_wr_en && w_mem_wr_addr == $past(r_cur_addr)))
        else $error("unmap write misplaced");

endmodule

`default_nettype wire

// File: hdl/pltw_store.sv
// table store memory with a clearing sweep after reset
`default_nettype none

module pltw_store #(
    parameter  int TABLE_FRAMES = 64,
    localparam int FRAME_W      = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1,
    localparam int ADDR_W       = FRAME_W + pltw_pkg::IDX_W
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_rd_en,
    input  wire logic [ADDR_W-1:0]            i_rd_addr,
    input  wire logic                         i_wr_en,
    input  wire logic [ADDR_W-1:0]            i_wr_addr,
    input  wire logic [pltw_pkg::WORD_W-1:0]  i_wr_data,
    output logic      [pltw_pkg::WORD_W-1:0]  o_rd_data,
    output logic                              o_clearing
);

    localparam int STORE_WORDS = TABLE_FRAMES * (1 << pltw_pkg::IDX_W);

    logic [pltw_pkg::WORD_W-1:0] r_mem [STORE_WORDS];
    logic [pltw_pkg::WORD_W-1:0] r_rd_data;
    logic [ADDR_W-1:0]           r_clr_addr;
    logic                        r_clearing;

    logic                        w_we;
    logic [ADDR_W-1:0]           w_waddr;
    logic [pltw_pkg::WORD_W-1:0] w_wdata;

    // sweep owns the write port until every word is zero
    always_comb begin
        if (r_clearing) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else begin
            w_we    = i_wr_en;
            w_waddr = i_wr_addr;
            w_wdata = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(STORE_WORDS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

// File: bench/tb_four_level_page_table_walker_core.sv
// self-checking testbench for the four-level page table walker core
`default_nettype none

module tb_four_level_page_table_walker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pltw_pkg::*;

    localparam int TABLE_FRAMES = 64;
    localparam int STORE_WORDS  = TABLE_FRAMES * 512;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 280;
    localparam int HOLD_CYCLES  = 300;

    // expected-result store plus a shadow of the table store and root frame
    class walk_scoreboard;
        bit [WORD_W-1:0] table_words [STORE_WORDS];
        bit [ROOT_W-1:0] root;
        t_result         expected_q [$];
        int              mismatches;
        int              results_seen;

        function new();
            root         = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(input string msg);
            if (mismatches < 40)
                $display("ERROR result %0d: %s", results_seen, msg);
            mismatches++;
        endtask

        // four dependent lookups from the root; leaf holds the pte word index on ok
        function t_status walk(input logic [VA_W-1:0] va, output logic [SIDX_W-1:0] leaf);
            logic [51:0]       frame;
            logic [SIDX_W-1:0] addr;
            logic [WORD_W-1:0] word;
            frame = 52'(root);
            leaf  = '0;
            for (int lvl = 0; lvl < 4; lvl++) begin
                if (frame >= TABLE_FRAMES)
                    return STATUS_RANGE;
                addr = {frame[ROOT_W-1:0], va[39 - 9 * lvl +: IDX_W]};
                word = table_words[addr];
                if (!word[0])
                    return STATUS_NOT_PRESENT;
                if (lvl == 3) begin
                    leaf = addr;
                    return STATUS_OK;
                end
                frame = word[WORD_W-1:PAGE_SHIFT];
            end
            return STATUS_NOT_PRESENT;
        endfunction

        function void note_command(input t_cmd cmd, input logic [VA_W-1:0] va,
                                   input logic [SIDX_W-1:0] sidx,
                                   input logic [WORD_W-1:0] sdata);
            t_result           r;
            logic [SIDX_W-1:0] leaf;
            r = '0;
            case (cmd)
                CMD_WRITE: begin
                    if (sidx < STORE_WORDS)
                        table_words[sidx] = sdata;
                    else
                        r.status = STATUS_RANGE;
                end
                CMD_READ: begin
                    if (sidx < STORE_WORDS)
                        r.read_data = table_words[sidx];
                    else
                        r.status = STATUS_RANGE;
                end
                default: begin
                    r.status = walk(va, leaf);
                    if (r.status == STATUS_OK) begin
                        r.phys_frame    = table_words[leaf] & ~64'hfff;
                        r.leaf_location = leaf;
                        if (cmd == CMD_UNMAP) begin
                            table_words[leaf] = '0;
                            r.released        = 1'b1;
                        end
                    end
                end
            endcase
            expected_q.push_back(r);
        endfunction

        task check_result(input t_result got);
            t_result want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report("result beat with no command outstanding");
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.phys_frame !== want.phys_frame)
                report($sformatf("phys_frame %h, want %h", got.phys_frame, want.phys_frame));
            if (got.leaf_location !== want.leaf_location)
                report($sformatf("leaf_location %h, want %h",
                                 got.leaf_location, want.leaf_location));
            if (got.released !== want.released)
                report($sformatf("released %b, want %b", got.released, want.released));
            if (got.read_data !== want.read_data)
                report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
        endtask
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [ROOT_W-1:0]     i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // virt_addr[47:0], store_index[62:48], store_data[126:63], zero[127]
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // cmd[1:0]
    logic [1:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // status[1:0], phys_frame[65:2], leaf_location[80:66], released[81],
    // read_data[145:82], zero[151:146]
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    walk_scoreboard  sb = new();
    int              cycle_count  = 0;
    int              items_sent   = 0;
    int              burst_left   = 0;
    bit              hold_request = 1'b0;
    logic [ROOT_W-1:0] root_setting = '0;

    four_level_page_table_walker_core #(
        .TABLE_FRAMES(TABLE_FRAMES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("four_level_page_table_walker_core: mismatch");
            $finish;
        end
    end

    // beats are picked up at the rising edge; results are checked before new commands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.root = i_cfg_wdata;
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(t_result'(m_axis_tdata[$bits(t_result)-1:0]));
            if (s_axis_tvalid && s_axis_tready)
                sb.note_command(t_cmd'(s_axis_tuser), s_axis_tdata[47:0],
                                s_axis_tdata[62:48], s_axis_tdata[126:63]);
        end
    end

    // result side backpressure: changing modes plus one long hold-off on request
    initial begin : result_stall
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {32'($urandom), 32'($urandom)};
    endfunction

    // table indices drawn from a small pool half the time so walks share tables
    function automatic logic [VA_W-1:0] rand_va();
        logic [VA_W-1:0] va;
        va = {16'($urandom), 32'($urandom)};
        for (int lvl = 0; lvl < 4; lvl++)
            if ($urandom_range(0, 1) == 0)
                va[39 - 9 * lvl +: IDX_W] = ($urandom_range(0, 4) == 4) ? 9'h1ff :
                                            9'($urandom_range(0, 3));
        return va;
    endfunction

    task automatic send_cmd(input t_cmd cmd, input logic [VA_W-1:0] va,
                            input logic [SIDX_W-1:0] sidx, input logic [WORD_W-1:0] sdata);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
                                                       $urandom_range(1, 10);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, sdata, sidx, va};
        s_axis_tuser  <= cmd;
        burst_left--;
        items_sent++;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    task automatic drain(input int settle);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_root(input logic [ROOT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        root_setting = value;
    endtask

    task automatic directed_cmds();
        logic [VA_W-1:0] va_top;
        va_top = '1;
        // fresh store: everything reads zero and walks stop at the root
        send_cmd(CMD_READ, '0, 15'd0, '0);
        send_cmd(CMD_TRANSLATE, '0, '0, '0);
        send_cmd(CMD_UNMAP, va_top, '0, '0);
        // full chain for the top address: frames 0 -> 1 -> 2 -> 3
        send_cmd(CMD_WRITE, '0, 15'd511, 64'h0000_0000_0000_1003);
        send_cmd(CMD_TRANSLATE, va_top, '0, '0);
        send_cmd(CMD_WRITE, '0, 15'(1 * 512 + 511), 64'h0000_0000_0000_2001);
        send_cmd(CMD_WRITE, '0, 15'(2 * 512 + 511), 64'h0000_0000_0000_3001);
        send_cmd(CMD_WRITE, '0, 15'(3 * 512 + 511), 64'hffff_ffff_ffff_ffff);
        send_cmd(CMD_TRANSLATE, va_top, '0, '0);
        send_cmd(CMD_UNMAP, va_top, '0, '0);
        // unmap of a leaf that is already gone
        send_cmd(CMD_UNMAP, va_top, '0, '0);
        send_cmd(CMD_READ, '0, 15'(3 * 512 + 511), '0);
        // leaf with flags but no present bit
        send_cmd(CMD_WRITE, '0, 15'(3 * 512 + 511), 64'hffff_ffff_ffff_fffe);
        send_cmd(CMD_TRANSLATE, va_top, '0, '0);
        // pointer to a frame past the store, then one with bit 63 set
        send_cmd(CMD_WRITE, '0, 15'(2 * 512 + 511), 64'h0000_0000_0004_0001);
        send_cmd(CMD_TRANSLATE, va_top, '0, '0);
        send_cmd(CMD_WRITE, '0, 15'(2 * 512 + 511), 64'h8000_0000_0000_3001);
        send_cmd(CMD_UNMAP, va_top, '0, '0);
        // low end: zero address through the last frame
        send_cmd(CMD_WRITE, '0, 15'd0, 64'h0000_0000_0003_f001);
        send_cmd(CMD_WRITE, '0, 15'(63 * 512), 64'h0000_0000_0000_5001);
        send_cmd(CMD_TRANSLATE, '0, '0, '0);
        send_cmd(CMD_WRITE, '0, 15'h7fff, '1);
        send_cmd(CMD_READ, '0, 15'h7fff, '0);
        send_cmd(CMD_WRITE, '0, 15'h7fff, '0);
    endtask

    // build a chain of table entries for one address, then use it
    task automatic walk_sequence();
        logic [VA_W-1:0]   va;
        logic [ROOT_W-1:0] frame;
        logic [ROOT_W-1:0] next;
        logic [SIDX_W-1:0] addr [4];
        logic [WORD_W-1:0] entry;
        int                depth;
        int                ops;
        int                pick;
        va    = rand_va();
        frame = root_setting;
        depth = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 4;
        for (int lvl = 0; lvl < depth; lvl++) begin
            addr[lvl] = {frame, va[39 - 9 * lvl +: IDX_W]};
            next      = 6'($urandom_range(0, TABLE_FRAMES - 1));
            if (lvl == 3) begin
                entry = rand_word();
                if ($urandom_range(0, 7) != 0)
                    entry[0] = 1'b1;
            end else begin
                case ($urandom_range(0, 19))
                    0:       entry = rand_word() & ~64'd1;
                    1:       entry = {12'h0, 40'($urandom_range(TABLE_FRAMES, 32'hffff)),
                                      12'($urandom) | 12'd1};
                    2:       entry = {1'b1, 45'd0, next, 12'($urandom) | 12'd1};
                    default: entry = {46'd0, next, 12'($urandom) | 12'd1};
                endcase
            end
            send_cmd(CMD_WRITE, '0, addr[lvl], entry);
            frame = next;
        end
        ops = $urandom_range(1, 3);
        repeat (ops) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                send_cmd(CMD_TRANSLATE, {va[47:12], 12'($urandom)}, 15'($urandom), rand_word());
            else if (pick < 8)
                send_cmd(CMD_UNMAP, {va[47:12], 12'($urandom)}, 15'($urandom), rand_word());
            else if (depth > 0)
                send_cmd(CMD_READ, va, addr[$urandom_range(0, depth - 1)], rand_word());
            else
                send_cmd(CMD_READ, va, 15'($urandom), rand_word());
        end
    endtask

    task automatic random_phase(input int n_items);
        int target;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(0, 9) < 7)
                walk_sequence();
            else
                send_cmd(t_cmd'($urandom_range(0, 3)),
                         ($urandom_range(0, 1) == 0) ? rand_va() : {16'($urandom), 32'($urandom)},
                         15'($urandom), rand_word());
        end
    endtask

    initial begin : main
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_root('0);
        directed_cmds();
        drain(10);
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0:       write_root('1);
                1:       write_root(6'd1);
                default: write_root(6'($urandom));
            endcase
            // one phase starts with the result side held off while commands pile up
            if (phase == 2)
                hold_request = 1'b1;
            random_phase(PHASE_ITEMS);
            drain(10);
        end
        drain(16);
        if (sb.mismatches == 0)
            $display("four_level_page_table_walker_core: match");
        else
            $display("four_level_page_table_walker_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// File: four_level_page_table_walker_core.f
hdl/pltw_pkg.sv
hdl/pltw_store.sv
hdl/four_level_page_table_walker_core.sv
bench/tb_four_level_page_table_walker_core.sv
